// File: sv/qpst_pkg.sv
// ---------------------------------------------------------------------------
// qpst_pkg
// Shared types and constants of the stabilization tau block.
// ---------------------------------------------------------------------------
`default_nettype none

package qpst_pkg;

  localparam int FRAC = 16;

  localparam logic [31:0] INV_RT2 = 32'd759250125;
  localparam logic [31:0] INV_RT3 = 32'd619925131;
  localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [63:0] TERM_LIM = 64'd1 << (FRAC + 32);

  localparam logic [1:0] CFG_TIME_STEP = 2'd0;
  localparam logic [1:0] CFG_VISC      = 2'd1;
  localparam logic [1:0] CFG_DENSITY   = 2'd2;
  localparam logic [1:0] CFG_DIMS      = 2'd3;

  localparam logic [1:0] GRP_VEL = 2'd0;
  localparam logic [1:0] GRP_DOT = 2'd1;
  localparam logic [1:0] GRP_X   = 2'd2;

  localparam logic [2:0] DIV_DIR0 = 3'd0;
  localparam logic [2:0] DIV_DIR1 = 3'd1;
  localparam logic [2:0] DIV_DIR2 = 3'd2;
  localparam logic [2:0] DIV_NU   = 3'd3;
  localparam logic [2:0] DIV_LEN  = 3'd4;
  localparam logic [2:0] DIV_TA   = 3'd5;
  localparam logic [2:0] DIV_TAU  = 3'd6;

  localparam logic [1:0] MUL_TB  = 2'd0;
  localparam logic [1:0] MUL_TC1 = 2'd1;
  localparam logic [1:0] MUL_TC2 = 2'd2;

  typedef struct packed {
    logic       load_in;
    logic       first;
    logic       mac_mul;
    logic       mac_load;
    logic       mac_add;
    logic [1:0] mac_grp;
    logic [1:0] mac_step;
    logic       sqrt_start;
    logic       sqrt_to_r;
    logic       div_start;
    logic [2:0] div_sel;
    logic       mul_start;
    logic [1:0] mul_sel;
    logic       dir_default;
    logic       sum_add;
    logic       zero_terms;
    logic       ta_max;
    logic       shift_init;
    logic       shift_step;
    logic       x_load;
    logic       tau_zero;
    logic       tau_max;
    logic       out_load;
  } qpst_cmd_t;

  typedef struct packed {
    logic last;
    logic speed_zero;
    logic sum_zero;
    logic dt_zero;
    logic huge;
    logic shift_more;
    logic r_zero;
    logic div_done;
    logic sqrt_done;
    logic mul_done;
    logic out_busy;
  } qpst_sts_t;

endpackage

`default_nettype wire

// File: sv/qpst_div.sv
// ---------------------------------------------------------------------------
// qpst_div
// Restoring divider, 64 by 64 bits, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module qpst_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [63:0] divisor,
  output logic             done,
  output logic [63:0]      quotient
);

  logic        busy;
  logic [5:0]  cnt;
  logic [63:0] rem;
  logic [63:0] dvs;
  logic [64:0] shifted;
  logic        fit;

  assign shifted = {rem, quotient[63]};
  assign fit = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quotient <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fit ? 64'(shifted - {1'b0, dvs}) : shifted[63:0];
      quotient <= {quotient[62:0], fit};
    end
  end

endmodule

`default_nettype wire

// File: sv/qpst_sqrt.sv
// ---------------------------------------------------------------------------
// qpst_sqrt
// Floor square root of a 64-bit word, one result bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module qpst_sqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] radicand,
  output logic             done,
  output logic [31:0]      root
);

  logic        busy;
  logic [4:0]  cnt;
  logic [63:0] x;
  logic [63:0] r;
  logic [63:0] b;
  logic [63:0] rb;

  assign rb = r + b;
  assign root = r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= radicand;
      r <= '0;
      b <= 64'd1 << 62;
    end else if (busy) begin
      if (x >= rb) begin
        x <= x - rb;
        r <= (r >> 1) + b;
      end else begin
        r <= r >> 1;
      end
      b <= b >> 2;
    end
  end

endmodule

`default_nettype wire

// File: sv/qpst_dp.sv
// ---------------------------------------------------------------------------
// qpst_dp
// Datapath: operand latches, multiply-accumulate, shared divider, square
// root, serial wide multiplier, term registers and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module qpst_dp
  import qpst_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire qpst_cmd_t          cmd,
  output qpst_sts_t               sts,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [30:0]        cfg_data,
  input  wire logic signed [31:0] vel_x,
  input  wire logic signed [31:0] vel_y,
  input  wire logic signed [31:0] vel_z,
  input  wire logic signed [31:0] grad_x,
  input  wire logic signed [31:0] grad_y,
  input  wire logic signed [31:0] grad_z,
  input  wire logic               last_node,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [31:0]             tau,
  output logic [31:0]             elem_length
);

  logic [30:0] time_step;
  logic [30:0] dyn_viscosity;
  logic [30:0] density;
  logic [1:0]  dimensions;

  logic               three;
  logic               last;
  logic [31:0]        m [3];
  logic [2:0]         vsign;
  logic signed [31:0] g [3];
  logic signed [31:0] dir [3];
  logic [31:0]        speed;
  logic [47:0]        sum;
  logic [63:0]        nu;
  logic [31:0]        len;
  logic [63:0]        ta;
  logic [63:0]        tb;
  logic [63:0]        tc;
  logic [63:0]        mxs;
  logic [4:0]         sh;
  logic [30:0]        x [3];
  logic [63:0]        r;
  logic [31:0]        tau_r;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod;
  logic signed [66:0] acc;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= 31'd1 << FRAC;
      dyn_viscosity <= 31'd1 << FRAC;
      density <= 31'd1 << FRAC;
      dimensions <= 2'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIME_STEP: time_step <= cfg_data;
        CFG_VISC:      dyn_viscosity <= cfg_data;
        CFG_DENSITY:   density <= cfg_data;
        CFG_DIMS:      dimensions <= cfg_data[1:0];
        default:       ;
      endcase
    end
  end

  // multiply-accumulate
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mac_grp)
      GRP_VEL: begin
        mul_a = {1'b0, m[cmd.mac_step]};
        mul_b = {1'b0, m[cmd.mac_step]};
      end
      GRP_DOT: begin
        mul_a = {dir[cmd.mac_step][31], dir[cmd.mac_step]};
        mul_b = {g[cmd.mac_step][31], g[cmd.mac_step]};
      end
      GRP_X: begin
        mul_a = {2'b00, x[cmd.mac_step]};
        mul_b = {2'b00, x[cmd.mac_step]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_mul) prod <= mul_a * mul_b;
    if (cmd.mac_load) acc <= {prod[65], prod};
    else if (cmd.mac_add) acc <= acc + {prod[65], prod};
  end

  // divider
  logic [63:0] div_dividend;
  logic [63:0] div_divisor;
  logic        div_done;
  logic [63:0] quot;
  logic [2:0]  div_dst;
  logic [1:0]  dk;

  assign dk = div_dst[1:0];

  always_comb begin
    div_dividend = '0;
    div_divisor = 64'd1;
    case (cmd.div_sel) inside
      DIV_DIR0, DIV_DIR1, DIV_DIR2: begin
        div_dividend = {2'b00, m[cmd.div_sel[1:0]], 30'd0};
        div_divisor = {32'd0, speed};
      end
      DIV_NU: begin
        div_dividend = {1'b0, dyn_viscosity, 32'd0};
        div_divisor = {33'd0, (density == '0) ? 31'd1 : density};
      end
      DIV_LEN: begin
        div_dividend = 64'd1 << (2 * FRAC + 1);
        div_divisor = {16'd0, sum};
      end
      DIV_TA: begin
        div_dividend = 64'd1 << (FRAC + 33);
        div_divisor = {33'd0, time_step};
      end
      DIV_TAU: begin
        div_dividend = TERM_LIM;
        div_divisor = r;
      end
      default: ;
    endcase
  end

  qpst_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quot)
  );

  // square root
  logic        sqrt_done;
  logic [31:0] root;
  logic        sqrt_dst;

  qpst_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (acc[63:0]),
    .done     (sqrt_done),
    .root     (root)
  );

  // serial wide multiplier: operand times the length sum
  logic         mul_busy;
  logic         mul_done;
  logic [5:0]   mul_cnt;
  logic [1:0]   mul_dst;
  logic [111:0] macc;
  logic [111:0] mshift;
  logic [47:0]  mbits;
  logic [111:0] macc_next;
  logic [63:0]  mul_op;

  assign macc_next = mbits[0] ? macc + mshift : macc;

  always_comb begin
    case (cmd.mul_sel)
      MUL_TB:  mul_op = {32'd0, speed};
      MUL_TC1: mul_op = nu;
      default: mul_op = tc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
      mul_done <= 1'b0;
      mul_cnt <= '0;
    end else begin
      mul_done <= 1'b0;
      if (cmd.mul_start) begin
        mul_busy <= 1'b1;
        mul_cnt <= '0;
      end else if (mul_busy) begin
        mul_cnt <= mul_cnt + 6'd1;
        if (mul_cnt == 6'd47) begin
          mul_busy <= 1'b0;
          mul_done <= 1'b1;
        end
      end
    end
  end

  logic [63:0] mx;
  logic [63:0] x_shift [3];

  always_comb begin
    mx = ta;
    if (tb > mx) mx = tb;
    if (tc > mx) mx = tc;
    x_shift[0] = ta >> sh;
    x_shift[1] = tb >> sh;
    x_shift[2] = tc >> sh;
  end

  logic [47:0] sum_add;
  logic [66:0] acc_mag;
  logic [48:0] sum_wide;

  assign acc_mag = acc[66] ? 67'(-acc) : acc;
  assign sum_add = {11'd0, acc_mag[66:30]};
  assign sum_wide = {1'b0, sum} + {1'b0, sum_add};

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      three <= (dimensions != 2'd2);
      last <= last_node;
      m[0] <= mag32(vel_x);
      m[1] <= mag32(vel_y);
      m[2] <= (dimensions != 2'd2) ? mag32(vel_z) : 32'd0;
      vsign <= {vel_z[31], vel_y[31], vel_x[31]};
      g[0] <= grad_x;
      g[1] <= grad_y;
      g[2] <= (dimensions != 2'd2) ? grad_z : 32'sd0;
      if (cmd.first) sum <= '0;
    end
    if (cmd.sum_add) sum <= sum_wide[48] ? SUM_MAX : sum_wide[47:0];
    if (cmd.dir_default) begin
      dir[0] <= three ? INV_RT3 : INV_RT2;
      dir[1] <= three ? INV_RT3 : INV_RT2;
      dir[2] <= three ? INV_RT3 : 32'd0;
    end
    if (cmd.div_start) div_dst <= cmd.div_sel;
    if (div_done) begin
      case (div_dst) inside
        DIV_DIR0, DIV_DIR1, DIV_DIR2:
          dir[dk] <= (vsign[dk] && m[dk] != '0) ? (~quot[31:0] + 32'd1) : quot[31:0];
        DIV_NU:  nu <= quot;
        DIV_LEN: len <= (quot[63:32] != '0) ? '1 : quot[31:0];
        DIV_TA:  ta <= quot;
        DIV_TAU: tau_r <= (quot[63:32] != '0) ? '1 : quot[31:0];
        default: ;
      endcase
    end
    if (cmd.sqrt_start) sqrt_dst <= cmd.sqrt_to_r;
    if (sqrt_done) begin
      if (sqrt_dst) r <= {32'd0, root} << sh;
      else speed <= root;
    end
    if (cmd.mul_start) begin
      mul_dst <= cmd.mul_sel;
      macc <= '0;
      mshift <= {48'd0, mul_op};
      mbits <= sum;
    end else if (mul_busy) begin
      macc <= macc_next;
      mshift <= mshift << 1;
      mbits <= mbits >> 1;
      if (mul_cnt == 6'd47) begin
        if (mul_dst == MUL_TB) tb <= (macc_next[111:64] != '0) ? '1 : macc_next[63:0];
        else tc <= (macc_next[111:80] != '0) ? '1 : macc_next[79:16];
      end
    end
    if (cmd.zero_terms) begin
      len <= '0;
      tb <= '0;
      tc <= '0;
    end
    if (cmd.ta_max) ta <= '1;
    if (cmd.shift_init) begin
      mxs <= mx;
      sh <= '0;
    end else if (cmd.shift_step) begin
      mxs <= mxs >> 1;
      sh <= sh + 5'd1;
    end
    if (cmd.x_load) begin
      x[0] <= x_shift[0][30:0];
      x[1] <= x_shift[1][30:0];
      x[2] <= x_shift[2][30:0];
    end
    if (cmd.tau_zero) tau_r <= '0;
    if (cmd.tau_max) tau_r <= '1;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      tau <= tau_r;
      elem_length <= len;
    end
  end

  assign sts.last = last;
  assign sts.speed_zero = (speed == '0);
  assign sts.sum_zero = (sum == '0);
  assign sts.dt_zero = (time_step == '0);
  assign sts.huge = (ta > TERM_LIM) || (tb > TERM_LIM) || (tc > TERM_LIM);
  assign sts.shift_more = (mxs[63:31] != '0);
  assign sts.r_zero = (r == '0);
  assign sts.div_done = div_done;
  assign sts.sqrt_done = sqrt_done;
  assign sts.mul_done = mul_done;
  assign sts.out_busy = out_valid && out_stall;

endmodule

`default_nettype wire

// File: sv/qpst_ctrl.sv
// ---------------------------------------------------------------------------
// qpst_ctrl
// Controller: sequences node accumulation, point setup and final terms.
// ---------------------------------------------------------------------------
`default_nettype none

module qpst_ctrl
  import qpst_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire qpst_sts_t sts,
  output qpst_cmd_t      cmd
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_MAC0    = 5'd1;
  localparam logic [4:0] S_MAC1    = 5'd2;
  localparam logic [4:0] S_MAC2    = 5'd3;
  localparam logic [4:0] S_MAC3    = 5'd4;
  localparam logic [4:0] S_SQGO    = 5'd5;
  localparam logic [4:0] S_SQWAIT  = 5'd6;
  localparam logic [4:0] S_SPDCHK  = 5'd7;
  localparam logic [4:0] S_DIVGO   = 5'd8;
  localparam logic [4:0] S_DIVWAIT = 5'd9;
  localparam logic [4:0] S_MULGO   = 5'd10;
  localparam logic [4:0] S_MULWAIT = 5'd11;
  localparam logic [4:0] S_SUMUP   = 5'd12;
  localparam logic [4:0] S_FIN     = 5'd13;
  localparam logic [4:0] S_TAGO    = 5'd14;
  localparam logic [4:0] S_CHECK   = 5'd15;
  localparam logic [4:0] S_SHIFT   = 5'd16;
  localparam logic [4:0] S_TAUGO   = 5'd17;
  localparam logic [4:0] S_OUT     = 5'd18;

  logic [4:0] state, state_next;
  logic [1:0] grp, grp_next;
  logic [2:0] dsel, dsel_next;
  logic [1:0] msel, msel_next;
  logic       first_pending, first_pending_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    grp_next = grp;
    dsel_next = dsel;
    msel_next = msel;
    first_pending_next = first_pending;
    cmd = '0;
    cmd.mac_grp = grp;
    cmd.div_sel = dsel;
    cmd.mul_sel = msel;
    cmd.sqrt_to_r = (grp == GRP_X);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          cmd.first = first_pending;
          grp_next = first_pending ? GRP_VEL : GRP_DOT;
          state_next = S_MAC0;
        end
      end
      S_MAC0: begin
        cmd.mac_mul = 1'b1;
        cmd.mac_step = 2'd0;
        state_next = S_MAC1;
      end
      S_MAC1: begin
        cmd.mac_mul = 1'b1;
        cmd.mac_step = 2'd1;
        cmd.mac_load = 1'b1;
        state_next = S_MAC2;
      end
      S_MAC2: begin
        cmd.mac_mul = 1'b1;
        cmd.mac_step = 2'd2;
        cmd.mac_add = 1'b1;
        state_next = S_MAC3;
      end
      S_MAC3: begin
        cmd.mac_add = 1'b1;
        state_next = (grp == GRP_DOT) ? S_SUMUP : S_SQGO;
      end
      S_SQGO: begin
        cmd.sqrt_start = 1'b1;
        state_next = S_SQWAIT;
      end
      S_SQWAIT: begin
        if (sts.sqrt_done) state_next = (grp == GRP_VEL) ? S_SPDCHK : S_TAUGO;
      end
      S_SPDCHK: begin
        if (sts.speed_zero) begin
          cmd.dir_default = 1'b1;
          grp_next = GRP_DOT;
          state_next = S_MAC0;
        end else begin
          dsel_next = DIV_DIR0;
          state_next = S_DIVGO;
        end
      end
      S_DIVGO: begin
        cmd.div_start = 1'b1;
        state_next = S_DIVWAIT;
      end
      S_DIVWAIT: begin
        if (sts.div_done) begin
          unique case (dsel)
            DIV_DIR0: begin
              dsel_next = DIV_DIR1;
              state_next = S_DIVGO;
            end
            DIV_DIR1: begin
              dsel_next = DIV_DIR2;
              state_next = S_DIVGO;
            end
            DIV_DIR2: begin
              grp_next = GRP_DOT;
              state_next = S_MAC0;
            end
            DIV_NU: begin
              dsel_next = DIV_LEN;
              state_next = S_DIVGO;
            end
            DIV_LEN: begin
              msel_next = MUL_TB;
              state_next = S_MULGO;
            end
            DIV_TA:  state_next = S_CHECK;
            DIV_TAU: state_next = S_OUT;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_MULGO: begin
        cmd.mul_start = 1'b1;
        state_next = S_MULWAIT;
      end
      S_MULWAIT: begin
        if (sts.mul_done) begin
          unique case (msel)
            MUL_TB: begin
              msel_next = MUL_TC1;
              state_next = S_MULGO;
            end
            MUL_TC1: begin
              msel_next = MUL_TC2;
              state_next = S_MULGO;
            end
            default: state_next = S_TAGO;
          endcase
        end
      end
      S_SUMUP: begin
        cmd.sum_add = 1'b1;
        if (sts.last) begin
          first_pending_next = 1'b1;
          state_next = S_FIN;
        end else begin
          first_pending_next = 1'b0;
          state_next = S_IDLE;
        end
      end
      S_FIN: begin
        if (sts.sum_zero) begin
          cmd.zero_terms = 1'b1;
          state_next = S_TAGO;
        end else begin
          dsel_next = DIV_NU;
          state_next = S_DIVGO;
        end
      end
      S_TAGO: begin
        if (sts.dt_zero) begin
          cmd.ta_max = 1'b1;
          state_next = S_CHECK;
        end else begin
          dsel_next = DIV_TA;
          state_next = S_DIVGO;
        end
      end
      S_CHECK: begin
        if (sts.huge) begin
          cmd.tau_zero = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.shift_init = 1'b1;
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (sts.shift_more) begin
          cmd.shift_step = 1'b1;
        end else begin
          cmd.x_load = 1'b1;
          grp_next = GRP_X;
          state_next = S_MAC0;
        end
      end
      S_TAUGO: begin
        if (sts.r_zero) begin
          cmd.tau_max = 1'b1;
          state_next = S_OUT;
        end else begin
          dsel_next = DIV_TAU;
          state_next = S_DIVGO;
        end
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      grp <= GRP_VEL;
      dsel <= DIV_DIR0;
      msel <= MUL_TB;
      first_pending <= 1'b1;
    end else begin
      state <= state_next;
      grp <= grp_next;
      dsel <= dsel_next;
      msel <= msel_next;
      first_pending <= first_pending_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/qp_stabilization_tau.sv
// ---------------------------------------------------------------------------
// qp_stabilization_tau
// Stabilization tau and directional element length per quadrature point.
//
// The input channel takes one node word per handshake: the point
// velocity (read on the first node of a point), the node shape gradient and
// a last-node flag. On the last node one result word carries tau and the
// element length, both unsigned Q16.16 and saturated.
// An inner node takes a load plus a three-step multiply-accumulate on the
// single 33x33 multiplier. The first node of a point adds a velocity pass,
// a square root and, unless the speed is zero, three divides for the flow
// direction. The last node adds up to four divides, up to three serial
// multiplies and, unless a term is too large, up to 18 normalizing shift
// steps and a norm pass; the shared divider takes most of the time.
// The result sits in an output register; the next point is worked on while
// it waits, and a new result holds until the receiver drops stall.
// Configuration writes are taken at any time and should be made while idle.
// Synchronous reset restores the register defaults and opens a new point.
// ---------------------------------------------------------------------------
`default_nettype none

module qp_stabilization_tau
  import qpst_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [30:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] vel_x,
  input  wire logic signed [31:0] vel_y,
  input  wire logic signed [31:0] vel_z,
  input  wire logic signed [31:0] grad_x,
  input  wire logic signed [31:0] grad_y,
  input  wire logic signed [31:0] grad_z,
  input  wire logic               last_node,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [31:0]             tau,
  output logic [31:0]             elem_length
);

  qpst_cmd_t cmd;
  qpst_sts_t sts;

  qpst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  qpst_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .vel_x       (vel_x),
    .vel_y       (vel_y),
    .vel_z       (vel_z),
    .grad_x      (grad_x),
    .grad_y      (grad_y),
    .grad_z      (grad_z),
    .last_node   (last_node),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .tau         (tau),
    .elem_length (elem_length)
  );

endmodule

`default_nettype wire
